[hw/rtl/sps_pkg.sv]
// ----------------------------------------------------------------------------
// sps_pkg
// Types, constants and functions of the two-round hash scrambler.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

  localparam int unsigned DATA_W = 18;

  // Width selector codes as they arrive on the input channel.
  localparam logic [1:0] OP_W14     = 2'd0;
  localparam logic [1:0] OP_W15     = 2'd1;
  localparam logic [1:0] OP_W18     = 2'd2;
  localparam logic [1:0] OP_W14_ALT = 2'd3;

  // Decoded network width.
  typedef enum logic [1:0] {
    WIDTH_14 = 2'd0,
    WIDTH_15 = 2'd1,
    WIDTH_18 = 2'd2
  } width_e;

  // Round select of the permutation layer.
  typedef enum logic {
    ROUND_A = 1'b0,
    ROUND_B = 1'b1
  } round_e;

  // Word carried between pipeline stages.
  typedef struct packed {
    width_e              width;
    logic [DATA_W-1:0]   data;
  } word_t;

  // Substitution boxes.
  localparam logic [2:0] SUB3 [8]  = '{3'd1, 3'd4, 3'd7, 3'd5, 3'd2, 3'd0, 3'd3, 3'd6};
  localparam logic [3:0] SUB4 [16] = '{4'd8, 4'd0, 4'd6, 4'd1, 4'd15, 4'd13, 4'd14, 4'd11,
                                       4'd2, 4'd12, 4'd3, 4'd7, 4'd5, 4'd4, 4'd9, 4'd10};

  // Permutations: output bit i takes substituted bit P[i].
  localparam logic [4:0] PERM14_A [14] = '{5'd2, 5'd9, 5'd10, 5'd3, 5'd6, 5'd11, 5'd0,
                                           5'd4, 5'd7, 5'd12, 5'd1, 5'd5, 5'd8, 5'd13};
  localparam logic [4:0] PERM14_B [14] = '{5'd6, 5'd10, 5'd0, 5'd3, 5'd7, 5'd11, 5'd1,
                                           5'd4, 5'd8, 5'd12, 5'd2, 5'd5, 5'd9, 5'd13};
  localparam logic [4:0] PERM15_A [15] = '{5'd5, 5'd10, 5'd11, 5'd2, 5'd6, 5'd7, 5'd12,
                                           5'd0, 5'd3, 5'd8, 5'd13, 5'd1, 5'd4, 5'd9,
                                           5'd14};
  localparam logic [4:0] PERM15_B [15] = '{5'd3, 5'd7, 5'd11, 5'd0, 5'd4, 5'd8, 5'd12,
                                           5'd1, 5'd5, 5'd9, 5'd13, 5'd2, 5'd6, 5'd10,
                                           5'd14};
  localparam logic [4:0] PERM18_A [18] = '{5'd6, 5'd13, 5'd14, 5'd0, 5'd5, 5'd7, 5'd10,
                                           5'd15, 5'd1, 5'd3, 5'd8, 5'd11, 5'd16, 5'd2,
                                           5'd4, 5'd9, 5'd12, 5'd17};
  localparam logic [4:0] PERM18_B [18] = '{5'd6, 5'd10, 5'd14, 5'd0, 5'd3, 5'd7, 5'd11,
                                           5'd15, 5'd1, 5'd4, 5'd8, 5'd12, 5'd16, 5'd2,
                                           5'd5, 5'd9, 5'd13, 5'd17};

  // Map the selector onto a network width; the spare code runs the 14-bit net.
  function automatic width_e decode_width(logic [1:0] op);
    width_e w;
    unique case (op)
      OP_W14, OP_W14_ALT: w = WIDTH_14;
      OP_W15:             w = WIDTH_15;
      OP_W18:             w = WIDTH_18;
      default:            w = WIDTH_14;
    endcase
    return w;
  endfunction

  // Substitution layer: 3-bit slices at the bottom, 4-bit slices above.
  // Bits above the width come out as zero.
  function automatic logic [DATA_W-1:0] substitute(logic [DATA_W-1:0] x, width_e w);
    logic [DATA_W-1:0] r;
    r = '0;
    case (w)
      WIDTH_15: begin
        r[2:0]   = SUB3[x[2:0]];
        r[6:3]   = SUB4[x[6:3]];
        r[10:7]  = SUB4[x[10:7]];
        r[14:11] = SUB4[x[14:11]];
      end
      WIDTH_18: begin
        r[2:0]   = SUB3[x[2:0]];
        r[5:3]   = SUB3[x[5:3]];
        r[9:6]   = SUB4[x[9:6]];
        r[13:10] = SUB4[x[13:10]];
        r[17:14] = SUB4[x[17:14]];
      end
      default: begin
        r[2:0]   = SUB3[x[2:0]];
        r[5:3]   = SUB3[x[5:3]];
        r[9:6]   = SUB4[x[9:6]];
        r[13:10] = SUB4[x[13:10]];
      end
    endcase
    return r;
  endfunction

  // Permutation layer for the given width and round; bits above the width stay zero.
  function automatic logic [DATA_W-1:0] permute(logic [DATA_W-1:0] x, width_e w,
                                                round_e rnd);
    logic [DATA_W-1:0] r;
    r = '0;
    case (w)
      WIDTH_15: begin
        for (int i = 0; i < 15; i++) begin
          r[i] = (rnd == ROUND_A) ? x[PERM15_A[i]] : x[PERM15_B[i]];
        end
      end
      WIDTH_18: begin
        for (int i = 0; i < 18; i++) begin
          r[i] = (rnd == ROUND_A) ? x[PERM18_A[i]] : x[PERM18_B[i]];
        end
      end
      default: begin
        for (int i = 0; i < 14; i++) begin
          r[i] = (rnd == ROUND_A) ? x[PERM14_A[i]] : x[PERM14_B[i]];
        end
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/sps_if.sv]
// ----------------------------------------------------------------------------
// sps_in_if / sps_out_if
// Valid/ready channels of the hash scrambler.
// ----------------------------------------------------------------------------
`default_nettype none

interface sps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [17:0] data_in;

  modport source (output valid, output opcode, output data_in, input ready);
  modport sink   (input valid, input opcode, input data_in, output ready);
endinterface

interface sps_out_if;
  logic        valid;
  logic        ready;
  logic [17:0] data_out;

  modport source (output valid, output data_out, input ready);
  modport sink   (input valid, input data_out, output ready);
endinterface

`default_nettype wire

[hw/rtl/sbox_permutation_hash_scrambler.sv]
// ----------------------------------------------------------------------------
// sbox_permutation_hash_scrambler
// Two-round substitution-permutation scrambler for 14, 15 or 18-bit hashes.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one word per handshake: opcode selects the network width
//   (0 = 14, 1 = 15, 2 = 18 bits, 3 = 14 bits) and data_in the hash; bits
//   above the width are ignored. out_o returns data_out, the scrambled hash,
//   with zeros above the width. Words leave in the order they arrive.
//   The block is a four-stage pipeline: substitution, round-one permutation,
//   substitution, round-two permutation, each closed by a register; out_o
//   is driven by the last register. Throughput is one word per cycle while
//   out_o.ready is high, set by the per-stage valid registers and a
//   combinational ready path: a full stage takes a word as its own moves on.
//   When the receiver drops out_o.ready, the stages hold their words and
//   ready falls back stage by stage, so in_i.ready stays high until the
//   pipeline is full; nothing is dropped or repeated.
//   Reset clears all stage valid bits; the block then accepts at once.
// ----------------------------------------------------------------------------
`default_nettype none

module sbox_permutation_hash_scrambler (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sps_in_if.sink    in_i,
  sps_out_if.source out_o
);
  import sps_pkg::*;

  localparam int unsigned Stages = 4;

  logic  valid [Stages+1];
  logic  ready [Stages+1];
  word_t word  [Stages+1];

  // Decode the selector at the entry of the pipeline.
  assign valid[0]      = in_i.valid;
  assign in_i.ready    = ready[0];
  assign word[0].width = decode_width(in_i.opcode);
  assign word[0].data  = in_i.data_in;

  // Round one.
  sps_sub_stage u_sub_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid[0]),
    .ready_o (ready[0]),
    .word_i  (word[0]),
    .valid_o (valid[1]),
    .ready_i (ready[1]),
    .word_o  (word[1])
  );

  sps_perm_stage u_perm_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .round_i (ROUND_A),
    .valid_i (valid[1]),
    .ready_o (ready[1]),
    .word_i  (word[1]),
    .valid_o (valid[2]),
    .ready_i (ready[2]),
    .word_o  (word[2])
  );

  // Round two.
  sps_sub_stage u_sub_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid[2]),
    .ready_o (ready[2]),
    .word_i  (word[2]),
    .valid_o (valid[3]),
    .ready_i (ready[3]),
    .word_o  (word[3])
  );

  sps_perm_stage u_perm_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .round_i (ROUND_B),
    .valid_i (valid[3]),
    .ready_o (ready[3]),
    .word_i  (word[3]),
    .valid_o (valid[4]),
    .ready_i (ready[4]),
    .word_o  (word[4])
  );

  // Output channel.
  assign out_o.valid    = valid[Stages];
  assign ready[Stages]  = out_o.ready;
  assign out_o.data_out = word[Stages].data;

endmodule

`default_nettype wire

[hw/rtl/sps_sub_stage.sv]
// ----------------------------------------------------------------------------
// sps_sub_stage
// Pipeline stage that runs the substitution layer and registers the word.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_sub_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire sps_pkg::word_t word_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output sps_pkg::word_t     word_o
);
  import sps_pkg::*;

  logic  valid_q, valid_d;
  word_t word_q,  word_d;

  // The stage takes a new word when it is empty or its word moves on.
  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_comb begin
    word_d       = word_i;
    word_d.data  = substitute(word_i.data, word_i.width);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload loads only when a word is taken in.
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

[hw/rtl/sps_perm_stage.sv]
// ----------------------------------------------------------------------------
// sps_perm_stage
// Pipeline stage that runs the bit permutation of one round and registers it.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_perm_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire sps_pkg::round_e round_i,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire sps_pkg::word_t  word_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output sps_pkg::word_t      word_o
);
  import sps_pkg::*;

  logic  valid_q, valid_d;
  word_t word_q,  word_d;

  // The stage takes a new word when it is empty or its word moves on.
  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_comb begin
    word_d      = word_i;
    word_d.data = permute(word_i.data, word_i.width, round_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload loads only when a word is taken in.
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

[tb/sv/tb_sbox_permutation_hash_scrambler.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sbox_permutation_hash_scrambler
// Self-checking bench for the two-round hash scrambler. Every accepted word is
// scrambled by a bench-side model of the substitution and permutation rounds.
// Each returned word is compared in order against that prediction. Directed
// corner words come first, then random words under three idle patterns. One
// long output hold-off fills the pipeline and backs up the input.
// ----------------------------------------------------------------------------
module tb_sbox_permutation_hash_scrambler;
  import sps_pkg::*;

  localparam int unsigned HALF_PERIOD    = 5;
  localparam int unsigned PIPE_LATENCY   = 4;
  localparam int unsigned RAND_PER_PHASE = 430;
  localparam int unsigned LONG_STALL     = 100;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [DATA_W-1:0] data;
  } hash_req_t;

  // Substitution boxes of the network.
  localparam logic [2:0] SBOX3 [8]  = '{3'd1, 3'd4, 3'd7, 3'd5, 3'd2, 3'd0, 3'd3, 3'd6};
  localparam logic [3:0] SBOX4 [16] = '{4'd8, 4'd0, 4'd6, 4'd1, 4'd15, 4'd13, 4'd14, 4'd11,
                                        4'd2, 4'd12, 4'd3, 4'd7, 4'd5, 4'd4, 4'd9, 4'd10};

  // Bit sources per width and round: output bit i takes substituted bit P[i].
  localparam logic [4:0] P14_A [14] = '{5'd2, 5'd9, 5'd10, 5'd3, 5'd6, 5'd11, 5'd0,
                                        5'd4, 5'd7, 5'd12, 5'd1, 5'd5, 5'd8, 5'd13};
  localparam logic [4:0] P14_B [14] = '{5'd6, 5'd10, 5'd0, 5'd3, 5'd7, 5'd11, 5'd1,
                                        5'd4, 5'd8, 5'd12, 5'd2, 5'd5, 5'd9, 5'd13};
  localparam logic [4:0] P15_A [15] = '{5'd5, 5'd10, 5'd11, 5'd2, 5'd6, 5'd7, 5'd12, 5'd0,
                                        5'd3, 5'd8, 5'd13, 5'd1, 5'd4, 5'd9, 5'd14};
  localparam logic [4:0] P15_B [15] = '{5'd3, 5'd7, 5'd11, 5'd0, 5'd4, 5'd8, 5'd12, 5'd1,
                                        5'd5, 5'd9, 5'd13, 5'd2, 5'd6, 5'd10, 5'd14};
  localparam logic [4:0] P18_A [18] = '{5'd6, 5'd13, 5'd14, 5'd0, 5'd5, 5'd7, 5'd10, 5'd15,
                                        5'd1, 5'd3, 5'd8, 5'd11, 5'd16, 5'd2, 5'd4, 5'd9,
                                        5'd12, 5'd17};
  localparam logic [4:0] P18_B [18] = '{5'd6, 5'd10, 5'd14, 5'd0, 5'd3, 5'd7, 5'd11, 5'd15,
                                        5'd1, 5'd4, 5'd8, 5'd12, 5'd16, 5'd2, 5'd5, 5'd9,
                                        5'd13, 5'd17};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sps_in_if  in_if ();
  sps_out_if out_if ();

  sbox_permutation_hash_scrambler u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  hash_req_t         pending_req [$];
  logic [DATA_W-1:0] expected_hash [$];

  logic        in_took = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_left = 0;
  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;
  int unsigned width_count [4] = '{0, 0, 0, 0};

  // Clock generation.
  always #HALF_PERIOD clk_i = ~clk_i;

  // Predicted scrambler output for one input word.
  function automatic logic [DATA_W-1:0] scramble_hash(logic [1:0] op, logic [DATA_W-1:0] din);
    int unsigned nbits;
    int unsigned n3;
    int unsigned pos;
    int unsigned src;
    logic [31:0] mask;
    logic [DATA_W-1:0] v;
    logic [DATA_W-1:0] s;
    case (op)
      OP_W15: begin
        nbits = 15;
        n3 = 1;
      end
      OP_W18: begin
        nbits = 18;
        n3 = 2;
      end
      default: begin
        nbits = 14;
        n3 = 2;
      end
    endcase
    mask = (32'd1 << nbits) - 32'd1;
    v = din & mask[DATA_W-1:0];
    for (int rnd = 0; rnd < 2; rnd++) begin
      // Substitution: 3-bit slices at the bottom, 4-bit slices up to the width.
      s = '0;
      pos = 0;
      for (int k = 0; k < n3; k++) begin
        s[pos +: 3] = SBOX3[v[pos +: 3]];
        pos += 3;
      end
      while (pos + 4 <= nbits) begin
        s[pos +: 4] = SBOX4[v[pos +: 4]];
        pos += 4;
      end
      // Permutation for this width and round; bits above the width stay zero.
      v = '0;
      for (int i = 0; i < nbits; i++) begin
        case (nbits)
          15:      src = (rnd == 0) ? P15_A[i] : P15_B[i];
          18:      src = (rnd == 0) ? P18_A[i] : P18_B[i];
          default: src = (rnd == 0) ? P14_A[i] : P14_B[i];
        endcase
        v[i] = s[src];
      end
    end
    return v;
  endfunction

  task automatic queue_hash(logic [1:0] op, logic [DATA_W-1:0] data);
    hash_req_t req;
    req.opcode = op;
    req.data   = data;
    pending_req.push_back(req);
    n_queued++;
  endtask

  task automatic queue_random(int unsigned count);
    logic [DATA_W-1:0] data;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9, 0) == 0) begin
        data = ($urandom_range(1, 0) != 0) ? '1 : '0;
      end else begin
        data = DATA_W'($urandom_range(262143, 0));
      end
      queue_hash(2'($urandom_range(3, 0)), data);
    end
  endtask

  // Returns at a rising edge once every queued word has been sent and checked.
  task automatic drain();
    do @(negedge clk_i);
    while (n_accepted != n_queued || n_checked != n_accepted || in_if.valid);
    @(posedge clk_i);
  endtask

  // Input driver: offers the next pending word once the current one is taken.
  always @(negedge clk_i) begin
    hash_req_t req;
    if (rst_ni && (!in_if.valid || in_took)) begin
      if (pending_req.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        req = pending_req.pop_front();
        in_if.valid   <= 1'b1;
        in_if.opcode  <= req.opcode;
        in_if.data_in <= req.data;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Output ready: random idling, or a counted hold-off when one is requested.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else begin
      out_if.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Monitor: record accepted words and check returned words in order.
  always @(posedge clk_i) begin
    logic [DATA_W-1:0] want;
    if (rst_ni) begin
      in_took <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        expected_hash.push_back(scramble_hash(in_if.opcode, in_if.data_in));
        width_count[in_if.opcode]++;
        n_accepted++;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_hash.size() == 0) begin
          $error("data_out: no word expected, actual 0x%05h", out_if.data_out);
          n_errors++;
        end else begin
          want = expected_hash.pop_front();
          if (out_if.data_out !== want) begin
            $error("data_out: expected 0x%05h, actual 0x%05h", want, out_if.data_out);
            n_errors++;
          end
          n_checked++;
        end
      end
    end
  end

  // Stimulus sequence.
  initial begin
    in_if.valid   = 1'b0;
    in_if.opcode  = OP_W14;
    in_if.data_in = '0;
    out_if.ready  = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Sender idles lightly, receiver heavily.
    send_idle_pct = 18;
    recv_idle_pct = 64;

    // Corner words on every selector code, including the spare code and
    // bits set only above the 14-bit and 15-bit widths.
    queue_hash(OP_W14, 18'h00000);
    queue_hash(OP_W14, 18'h3FFFF);
    queue_hash(OP_W14, 18'h15555);
    queue_hash(OP_W14, 18'h2AAAA);
    queue_hash(OP_W14, 18'h3C000);
    queue_hash(OP_W15, 18'h00000);
    queue_hash(OP_W15, 18'h3FFFF);
    queue_hash(OP_W15, 18'h15555);
    queue_hash(OP_W15, 18'h2AAAA);
    queue_hash(OP_W15, 18'h38000);
    queue_hash(OP_W18, 18'h00000);
    queue_hash(OP_W18, 18'h3FFFF);
    queue_hash(OP_W18, 18'h15555);
    queue_hash(OP_W18, 18'h2AAAA);
    queue_hash(OP_W18, 18'h20000);
    queue_hash(OP_W14_ALT, 18'h00000);
    queue_hash(OP_W14_ALT, 18'h3FFFF);
    queue_hash(OP_W14_ALT, 18'h15555);
    queue_hash(OP_W14_ALT, 18'h2AAAA);
    queue_hash(OP_W14_ALT, 18'h3C000);
    queue_random(RAND_PER_PHASE);
    drain();

    // Sender idles heavily, receiver lightly.
    send_idle_pct = 64;
    recv_idle_pct = 18;
    queue_random(RAND_PER_PHASE);
    drain();

    // No idling; partway through, hold the output off long enough that the
    // pipeline fills and the input backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(RAND_PER_PHASE);
    do @(negedge clk_i);
    while (n_accepted + RAND_PER_PHASE < n_queued + 40);
    @(posedge clk_i);
    stall_left = LONG_STALL;
    drain();

    repeat (2 * PIPE_LATENCY) @(posedge clk_i);
    $display("Scrambled %0d words: 14-bit %0d, spare code %0d, 15-bit %0d, 18-bit %0d.",
             n_checked, width_count[OP_W14], width_count[OP_W14_ALT],
             width_count[OP_W15], width_count[OP_W18]);
    $display("Idle mixes on both sides plus one %0d-cycle output hold-off; %0d errors.",
             LONG_STALL, n_errors);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
